>>> hdl/snmt_pkg.sv
// ----------------------------------------------------------------------------
// snmt_pkg: shared types and constants
// Field widths, action and status codes, and the control/status bundles that
// pass between the sorted nearest-match table controller and datapath.
// ----------------------------------------------------------------------------
package snmt_pkg;

  localparam int KEY_BITS      = 40;
  localparam int PAYLOAD_BITS  = 32;
  localparam int THR_BITS      = 20;
  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(240);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_REFUSED  = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;
  localparam logic [1:0] ST_MATCH    = 2'd3;

  typedef struct packed {
    logic [1:0]              action;
    logic [KEY_BITS-1:0]     anchor_time;
    logic [PAYLOAD_BITS-1:0] entry_payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [KEY_BITS-1:0]     match_time;
    logic [PAYLOAD_BITS-1:0] match_payload;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic load_item;
    logic clear_count;
    logic set_done;
    logic set_refused;
    logic ins_init;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic srch_init;
    logic srch_rd;
    logic srch_step;
    logic later_rd;
    logic later_eval;
    logic earlier_rd;
    logic earlier_eval;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       idx_zero;
    logic       rd_gt;
    logic       lo_lt_hi;
    logic       lo_lt_cnt;
    logic       lo_zero;
    logic       out_free;
  } dp_sts_t;

endpackage

>>> hdl/sorted_nearest_match_table_top.sv
// Per request: a clear, an unused action or a refused insert goes straight to the result;
// an insert shifts larger entries up one at a time until its slot is found; a lookup runs
// a binary search of about ceil(log2(count + 1)) steps, then checks the neighbours on either side.
// One request in flight; the next is taken once its result is registered, even while
// that result waits on out_ready_i.
// Reset: table empty, threshold 240, no clearing pass; entry memory is not reset.
// ----------------------------------------------------------------------------
// sorted_nearest_match_table_top: sorted nearest-match table
// Time-key sorted table with ordered insert, clear and nearest lookup under
// a programmable distance threshold.
// ----------------------------------------------------------------------------
module sorted_nearest_match_table_top #(
  parameter int TABLE_DEPTH = snmt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  snmt_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output snmt_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [snmt_pkg::THR_BITS-1:0] cfg_data_i
);

  snmt_pkg::dp_cmd_t cmd;
  snmt_pkg::dp_sts_t sts;

  snmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  snmt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

>>> hdl/snmt_dp.sv
// ----------------------------------------------------------------------------
// snmt_dp: table datapath
// Entry memory, fill count, search bounds, shift index, candidate compare,
// threshold register and the output register.
// ----------------------------------------------------------------------------
module snmt_dp #(
  parameter int TABLE_DEPTH = snmt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  snmt_pkg::in_item_t            in_item_i,
  input  logic                          cfg_we_i,
  input  logic [snmt_pkg::THR_BITS-1:0] cfg_data_i,
  input  logic                          out_ready_i,
  input  snmt_pkg::dp_cmd_t             cmd_i,
  output snmt_pkg::dp_sts_t             sts_o,
  output logic                          out_valid_o,
  output snmt_pkg::out_item_t           out_item_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KB = snmt_pkg::KEY_BITS;
  localparam int TB = snmt_pkg::THR_BITS;

  snmt_pkg::entry_t mem [TABLE_DEPTH];
  snmt_pkg::entry_t rd_q;

  snmt_pkg::in_item_t  item_q, item_d;
  snmt_pkg::out_item_t res_q, res_d;
  snmt_pkg::out_item_t out_item_q, out_item_d;
  logic                out_valid_q, out_valid_d;
  logic [TB-1:0]       thr_q, thr_d;
  logic [TB-1:0]       best_q, best_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       lo_q, lo_d;
  logic [CW-1:0]       hi_q, hi_d;
  logic [CW-1:0]       mid_q, mid_d;
  logic [CW-1:0]       idx_q, idx_d;

  logic [CW-1:0]       mid_w;
  logic [CW-1:0]       rd_addr_w;
  logic [CW-1:0]       wr_addr_w;
  logic                rd_en;
  logic                wr_en;
  snmt_pkg::entry_t    wr_data;
  logic [KB-1:0]       delta;
  logic                delta_hit;

  assign mid_w = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    rd_addr_w = lo_q;
    if (cmd_i.ins_rd) begin
      rd_addr_w = idx_q - CW'(1);
    end else if (cmd_i.srch_rd) begin
      rd_addr_w = mid_w;
    end else if (cmd_i.earlier_rd) begin
      rd_addr_w = lo_q - CW'(1);
    end
  end

  assign rd_en     = cmd_i.ins_rd | cmd_i.srch_rd | cmd_i.later_rd | cmd_i.earlier_rd;
  assign wr_en     = cmd_i.ins_shift | cmd_i.ins_place;
  assign wr_addr_w = idx_q;
  assign wr_data   = cmd_i.ins_shift ? rd_q :
                     snmt_pkg::entry_t'{key: item_q.anchor_time,
                                        payload: item_q.entry_payload};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr_w[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr_w[AW-1:0]];
    end
  end

  assign delta     = cmd_i.earlier_eval ? (item_q.anchor_time - rd_q.key)
                                        : (rd_q.key - item_q.anchor_time);
  assign delta_hit = delta < KB'(best_q);

  always_comb begin
    item_d      = item_q;
    res_d       = res_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q;
    thr_d       = thr_q;
    best_d      = best_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;

    if (cfg_we_i) begin
      thr_d = cfg_data_i;
    end
    if (cmd_i.load_item) begin
      item_d = in_item_i;
    end
    if (cmd_i.clear_count) begin
      count_d = '0;
    end
    if (cmd_i.set_done) begin
      res_d = '{status: snmt_pkg::ST_DONE, match_time: '0, match_payload: '0};
    end
    if (cmd_i.set_refused) begin
      res_d = '{status: snmt_pkg::ST_REFUSED, match_time: '0, match_payload: '0};
    end
    if (cmd_i.ins_init) begin
      idx_d = count_q;
    end
    if (cmd_i.ins_shift) begin
      idx_d = idx_q - CW'(1);
    end
    if (cmd_i.ins_place) begin
      count_d = count_q + CW'(1);
      res_d   = '{status: snmt_pkg::ST_DONE, match_time: '0, match_payload: '0};
    end
    if (cmd_i.srch_init) begin
      lo_d   = '0;
      hi_d   = count_q;
      best_d = thr_q;
      res_d  = '{status: snmt_pkg::ST_NO_MATCH, match_time: '0, match_payload: '0};
    end
    if (cmd_i.srch_rd) begin
      mid_d = mid_w;
    end
    if (cmd_i.srch_step) begin
      if (rd_q.key < item_q.anchor_time) begin
        lo_d = mid_q + CW'(1);
      end else begin
        hi_d = mid_q;
      end
    end
    if ((cmd_i.later_eval || cmd_i.earlier_eval) && delta_hit) begin
      best_d = delta[TB-1:0];
      res_d  = '{status: snmt_pkg::ST_MATCH, match_time: rd_q.key,
                 match_payload: rd_q.payload};
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      out_item_d  = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= snmt_pkg::THR_RESET;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      thr_q       <= thr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
    best_q     <= best_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    idx_q      <= idx_d;
  end

  assign sts_o.action    = item_q.action;
  assign sts_o.full      = (count_q == CW'(TABLE_DEPTH));
  assign sts_o.idx_zero  = (idx_q == '0);
  assign sts_o.rd_gt     = (rd_q.key > item_q.anchor_time);
  assign sts_o.lo_lt_hi  = (lo_q < hi_q);
  assign sts_o.lo_lt_cnt = (lo_q < count_q);
  assign sts_o.lo_zero   = (lo_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> hdl/snmt_ctrl.sv
// ----------------------------------------------------------------------------
// snmt_ctrl: table controller
// Sequences insert shifts, binary search, neighbor compares and result
// hand-off by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module snmt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  snmt_pkg::dp_sts_t sts_i,
  output snmt_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE        = 11'b00000000001,
    S_DECODE      = 11'b00000000010,
    S_INS_CHK     = 11'b00000000100,
    S_INS_CMP     = 11'b00000001000,
    S_SRCH        = 11'b00000010000,
    S_SRCH_CMP    = 11'b00000100000,
    S_LATER       = 11'b00001000000,
    S_LATER_CMP   = 11'b00010000000,
    S_EARLIER     = 11'b00100000000,
    S_EARLIER_CMP = 11'b01000000000,
    S_FINISH      = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.action)
          snmt_pkg::ACT_INSERT: begin
            if (sts_i.full) begin
              cmd_o.set_refused = 1'b1;
              state_d           = S_FINISH;
            end else begin
              cmd_o.ins_init = 1'b1;
              state_d        = S_INS_CHK;
            end
          end
          snmt_pkg::ACT_CLEAR: begin
            cmd_o.clear_count = 1'b1;
            cmd_o.set_done    = 1'b1;
            state_d           = S_FINISH;
          end
          snmt_pkg::ACT_LOOKUP: begin
            cmd_o.srch_init = 1'b1;
            state_d         = S_SRCH;
          end
          default: begin
            cmd_o.set_done = 1'b1;
            state_d        = S_FINISH;
          end
        endcase
      end
      S_INS_CHK: begin
        if (sts_i.idx_zero) begin
          cmd_o.ins_place = 1'b1;
          state_d         = S_FINISH;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.rd_gt) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = S_INS_CHK;
        end else begin
          cmd_o.ins_place = 1'b1;
          state_d         = S_FINISH;
        end
      end
      S_SRCH: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.srch_rd = 1'b1;
          state_d       = S_SRCH_CMP;
        end else begin
          state_d = S_LATER;
        end
      end
      S_SRCH_CMP: begin
        cmd_o.srch_step = 1'b1;
        state_d         = S_SRCH;
      end
      S_LATER: begin
        if (sts_i.lo_lt_cnt) begin
          cmd_o.later_rd = 1'b1;
          state_d        = S_LATER_CMP;
        end else begin
          state_d = S_EARLIER;
        end
      end
      S_LATER_CMP: begin
        cmd_o.later_eval = 1'b1;
        state_d          = S_EARLIER;
      end
      S_EARLIER: begin
        if (sts_i.lo_zero) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.earlier_rd = 1'b1;
          state_d          = S_EARLIER_CMP;
        end
      end
      S_EARLIER_CMP: begin
        cmd_o.earlier_eval = 1'b1;
        state_d            = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule
